// ===== rtl/wwg_pkg.sv =====
// ---------------------------------------------------------------------------
// wwg_pkg
// Grid size, cell and operation codes, and the row-wide update functions of
// the Wireworld grid engine.
// ---------------------------------------------------------------------------
package wwg_pkg;

    localparam int GRID_WIDTH  = 128;
    localparam int GRID_HEIGHT = 128;

    localparam int COL_W = $clog2(GRID_WIDTH);
    localparam int ROW_W = $clog2(GRID_HEIGHT);
    localparam int CNT_W = $clog2(GRID_HEIGHT + 1);

    // one memory word holds a whole grid row
    typedef logic [GRID_WIDTH-1:0][1:0] t_row;

    localparam logic [1:0] CELL_EMPTY = 2'd0;
    localparam logic [1:0] CELL_WIRE  = 2'd1;
    localparam logic [1:0] CELL_HEAD  = 2'd2;
    localparam logic [1:0] CELL_TAIL  = 2'd3;

    localparam logic [2:0] OP_WRITE = 3'd0;
    localparam logic [2:0] OP_READ  = 3'd1;
    localparam logic [2:0] OP_TICK  = 3'd2;
    localparam logic [2:0] OP_CLEAR = 3'd3;
    localparam logic [2:0] OP_STRIP = 3'd4;

    // next generation of row mid, given the old rows either side of it
    function automatic t_row tick_row(input t_row up, input t_row mid, input t_row dn);
        logic [GRID_WIDTH+1:0] hu;
        logic [GRID_WIDTH+1:0] hm;
        logic [GRID_WIDTH+1:0] hd;
        logic [3:0]            n;
        t_row                  res;
        hu = '0;
        hm = '0;
        hd = '0;
        for (int c = 0; c < GRID_WIDTH; c++) begin
            hu[c+1] = (up[c]  == CELL_HEAD);
            hm[c+1] = (mid[c] == CELL_HEAD);
            hd[c+1] = (dn[c]  == CELL_HEAD);
        end
        for (int c = 0; c < GRID_WIDTH; c++) begin
            n = 4'(hu[c]) + 4'(hu[c+1]) + 4'(hu[c+2]) + 4'(hm[c]) + 4'(hm[c+2])
              + 4'(hd[c]) + 4'(hd[c+1]) + 4'(hd[c+2]);
            case (mid[c])
                CELL_HEAD: res[c] = CELL_TAIL;
                CELL_TAIL: res[c] = CELL_WIRE;
                CELL_WIRE: res[c] = (n == 4'd1 || n == 4'd2) ? CELL_HEAD : CELL_WIRE;
                default:   res[c] = CELL_EMPTY;
            endcase
        end
        return res;
    endfunction

    // turn heads and tails back into conductor
    function automatic t_row strip_row(input t_row row);
        t_row res;
        for (int c = 0; c < GRID_WIDTH; c++) begin
            res[c] = row[c][1] ? CELL_WIRE : row[c];
        end
        return res;
    endfunction

endpackage

// ===== rtl/wireworld_grid_engine_unit.sv =====
// ---------------------------------------------------------------------------
// wireworld_grid_engine_unit
// Wireworld grid held row by row in a single-port-read, single-port-write
// memory; cell access, generation sweep, clear and electron removal.
// ---------------------------------------------------------------------------
// Usage:
//   Input words (operation, col, row, new_value) enter on i_in_valid while
//   o_in_stall is low; each yields one output word (read_value, done_res) on
//   o_out_valid, taken when i_out_stall is low. One operation is in work at a
//   time; o_in_stall is high from acceptance until its word is handed to the
//   output register, which then lets the next word in while it waits.
//   Each memory word is one grid row, so cost is set by the row count H
//   (GRID_HEIGHT) and the registered memory read:
//     write / read cell:                row read, then rewritten or read out
//     unknown code:                     straight to the response state
//     clear all, remove electrons:      every row written in turn
//     tick generation:                  each row rewritten in turn
//                                       (row N-1, N held in registers
//                                       while row N+1 is read)
//   After reset the block sweeps zeros through all H rows with o_in_stall
//   high. While the receiver stalls, the output word holds and a finished
//   operation waits in its response state.
// ---------------------------------------------------------------------------
module wireworld_grid_engine_unit
    import wwg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_operation,
    input  logic [6:0] i_col,
    input  logic [6:0] i_row,
    input  logic [1:0] i_new_value,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_read_value,
    output logic       o_done_res
);

    typedef enum logic [6:0] {
        S_CLR   = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_WMOD  = 7'b0000100,
        S_RD    = 7'b0001000,
        S_TICK  = 7'b0010000,
        S_STRIP = 7'b0100000,
        S_RESP  = 7'b1000000
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_row, n_row;
    logic               r_boot, n_boot;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_sel, n_sel;
    logic [1:0]         r_val, n_val;
    logic [1:0]         r_pend_rd, n_pend_rd;
    logic               r_pend_done, n_pend_done;
    t_row               r_above, n_above;
    t_row               r_mid, n_mid;
    logic               r_out_valid, n_out_valid;
    logic [1:0]         r_out_rd, n_out_rd;
    logic               r_out_done, n_out_done;

    t_row               r_grid [GRID_HEIGHT];
    t_row               r_rdata;

    logic               mem_re, mem_we;
    logic [ROW_W-1:0]   mem_raddr, mem_waddr;
    t_row               mem_wdata;

    t_row               below;
    logic               in_acc, on_grid, out_free, at_end, last_row;

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_out_rd;
    assign o_done_res   = r_out_done;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign on_grid  = (32'(i_col) < GRID_WIDTH) && (32'(i_row) < GRID_HEIGHT);
    assign out_free = !r_out_valid || !i_out_stall;
    assign at_end   = (r_row == CNT_W'(GRID_HEIGHT));
    assign last_row = (r_row == CNT_W'(GRID_HEIGHT - 1));
    // rows below the grid read as empty
    assign below    = at_end ? '0 : r_rdata;

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_boot      = r_boot;
        n_col       = r_col;
        n_sel       = r_sel;
        n_val       = r_val;
        n_pend_rd   = r_pend_rd;
        n_pend_done = r_pend_done;
        n_above     = r_above;
        n_mid       = r_mid;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_rd    = r_out_rd;
        n_out_done  = r_out_done;
        mem_re      = 1'b0;
        mem_we      = 1'b0;
        mem_raddr   = '0;
        mem_waddr   = '0;
        mem_wdata   = '0;

        case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = ROW_W'(r_row);
                if (last_row) begin
                    n_row       = '0;
                    n_boot      = 1'b0;
                    n_pend_rd   = CELL_EMPTY;
                    n_pend_done = 1'b1;
                    n_state     = r_boot ? S_IDLE : S_RESP;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_col       = COL_W'(i_col);
                    n_sel       = ROW_W'(i_row);
                    n_val       = i_new_value;
                    n_pend_rd   = CELL_EMPTY;
                    n_pend_done = 1'b1;
                    n_row       = '0;
                    case (i_operation)
                        OP_WRITE, OP_READ: begin
                            if (on_grid) begin
                                mem_re    = 1'b1;
                                mem_raddr = ROW_W'(i_row);
                                n_state   = (i_operation == OP_WRITE) ? S_WMOD : S_RD;
                            end else begin
                                n_state = S_RESP;
                            end
                        end
                        OP_TICK: begin
                            mem_re  = 1'b1;
                            n_mid   = '0;
                            n_state = S_TICK;
                        end
                        OP_CLEAR: n_state = S_CLR;
                        OP_STRIP: begin
                            mem_re  = 1'b1;
                            n_state = S_STRIP;
                        end
                        default: begin
                            n_pend_done = 1'b0;
                            n_state     = S_RESP;
                        end
                    endcase
                end
            end
            S_WMOD: begin
                mem_we           = 1'b1;
                mem_waddr        = r_sel;
                mem_wdata        = r_rdata;
                mem_wdata[r_col] = r_val;
                n_state          = S_RESP;
            end
            S_RD: begin
                n_pend_rd = r_rdata[r_col];
                n_state   = S_RESP;
            end
            S_TICK: begin
                // row r_row arrives now; rewrite the row above it
                if (r_row < CNT_W'(GRID_HEIGHT - 1)) begin
                    mem_re    = 1'b1;
                    mem_raddr = ROW_W'(r_row + 1'b1);
                end
                if (r_row != '0) begin
                    mem_we    = 1'b1;
                    mem_waddr = ROW_W'(r_row - 1'b1);
                    mem_wdata = tick_row(r_above, r_mid, below);
                end
                n_above = r_mid;
                n_mid   = below;
                if (at_end) begin
                    n_state = S_RESP;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end
            S_STRIP: begin
                mem_we    = 1'b1;
                mem_waddr = ROW_W'(r_row);
                mem_wdata = strip_row(r_rdata);
                if (last_row) begin
                    n_state = S_RESP;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = ROW_W'(r_row + 1'b1);
                    n_row     = r_row + 1'b1;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_rd    = r_pend_rd;
                    n_out_done  = r_pend_done;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_row       <= '0;
            r_boot      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_boot      <= n_boot;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col       <= n_col;
        r_sel       <= n_sel;
        r_val       <= n_val;
        r_pend_rd   <= n_pend_rd;
        r_pend_done <= n_pend_done;
        r_above     <= n_above;
        r_mid       <= n_mid;
        r_out_rd    <= n_out_rd;
        r_out_done  <= n_out_done;
    end

    // grid memory: one row written and one row read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_grid[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_grid[mem_raddr];
        end
    end

    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("grid row read and written in the same cycle");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE))
        else $error("accepted word did not start any work");

    a_out_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_RESP))
        else $error("output word raised outside the response state");

    a_fail_reads_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_done_res) |-> (o_read_value == CELL_EMPTY))
        else $error("unknown operation returned a cell value");

    a_tick_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK) |-> (r_row <= CNT_W'(GRID_HEIGHT)))
        else $error("generation sweep row counter out of range");

endmodule
